// ===== sv/ttcw_pkg.sv =====
`timescale 1ns / 1ps

package ttcw_pkg;

    // Default screen geometry and tab spacing.
    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;
    localparam int TAB_STOP_DEF      = 8;

    // Request kinds.
    localparam logic [1:0] KIND_PUT      = 2'd0;
    localparam logic [1:0] KIND_SET_COL  = 2'd1;
    localparam logic [1:0] KIND_SET_LINE = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    // Control characters that move the cursor instead of being stored.
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_RETURN    = 8'd13;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;      // take the request on the input ports
        logic clear;     // write one zero cell and advance the clear counters
        logic load_out;  // copy the finished result into the output register
    } ttcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll_req;    // the request on the ports scrolls the screen
        logic clr_last_col;  // clear counter sits on the last column
        logic clr_last_row;  // clear counter sits on the last row
    } ttcw_sts_t;

endpackage

// ===== sv/ttcw_ctrl.sv =====
`timescale 1ns / 1ps

module ttcw_ctrl import ttcw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ttcw_cmd_t cmd_o,
    input  ttcw_sts_t sts_i
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next    = state_reg;
        cmd_o.exec     = 1'b0;
        cmd_o.clear    = 1'b0;
        cmd_o.load_out = 1'b0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd_o.clear = 1'b1;
                if (sts_i.clr_last_col && sts_i.clr_last_row) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.exec = 1'b1;
                    state_next = sts_i.scroll_req ? ST_SCROLL : ST_FINISH;
                end
            end
            ST_SCROLL: begin
                cmd_o.clear = 1'b1;
                if (sts_i.clr_last_col) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd_o.load_out = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd_o.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // No result shows while the screen is still being cleared after reset.
    a_quiet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result during clear pass");

    // A scrolling request is always followed by the bottom-line clear.
    a_scroll_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_o.exec && sts_i.scroll_req) |=> state_reg == ST_SCROLL)
        else $error("scroll without line clear");

    // The line clear does not end before its last column.
    a_full_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && !sts_i.clr_last_col) |=> state_reg == ST_SCROLL)
        else $error("line clear cut short");

endmodule

// ===== sv/ttcw_dp.sv =====
`timescale 1ns / 1ps

module ttcw_dp import ttcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int TAB_STOP      = TAB_STOP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ttcw_cmd_t  cmd_i,
    output ttcw_sts_t  sts_o,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_char_color,
    input  logic [7:0] s_target_index,
    input  logic [6:0] s_read_column,
    input  logic [4:0] s_read_line,
    output logic       m_accepted,
    output logic [6:0] m_cursor_column,
    output logic [4:0] m_cursor_line,
    output logic       m_scrolled,
    output logic [7:0] m_cell_char,
    output logic [7:0] m_cell_color
);

    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int LINE_W = $clog2(SCREEN_HEIGHT);
    localparam int STOP_W = $clog2(3 * SCREEN_WIDTH);
    localparam int ADDR_W = LINE_W + COL_W;
    localparam int DEPTH  = SCREEN_HEIGHT << COL_W;

    // Cursor is kept as column and logical line; top_reg is the physical row
    // that currently shows logical line 0, so a scroll only moves top_reg.
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] top_reg, top_next;
    logic [COL_W-1:0]  clr_col_reg;
    logic [LINE_W-1:0] clr_row_reg;

    logic              res_acc_reg, res_scr_reg, res_rd_reg;
    logic              out_acc_reg, out_scr_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic [15:0]       out_cell_reg;

    logic [15:0]       mem [DEPTH];
    logic [15:0]       rdata_reg;

    logic [STOP_W-1:0] tab_stop_tbl [SCREEN_WIDTH];
    logic [STOP_W-1:0] stop, stop_col;
    logic [1:0]        dl;
    logic [LINE_W+1:0] line_sum;
    logic [LINE_W:0]   cur_sum, rd_sum;
    logic [LINE_W-1:0] cur_phys, rd_phys, top_inc;
    logic              advance, put_wr, acc_flag, scroll_flag, read_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0]       wr_data;

    // Next tab stop for every column, folded to constants.
    always_comb begin
        for (int i = 0; i < SCREEN_WIDTH; i++) begin
            tab_stop_tbl[i] = STOP_W'((i / TAB_STOP + 1) * TAB_STOP);
        end
    end

    always_comb begin
        cur_sum  = (LINE_W+1)'(line_reg) + (LINE_W+1)'(top_reg);
        cur_phys = (cur_sum >= (LINE_W+1)'(SCREEN_HEIGHT))
                 ? LINE_W'(cur_sum - (LINE_W+1)'(SCREEN_HEIGHT)) : LINE_W'(cur_sum);
        rd_sum   = (LINE_W+1)'(s_read_line[LINE_W-1:0]) + (LINE_W+1)'(top_reg);
        rd_phys  = (rd_sum >= (LINE_W+1)'(SCREEN_HEIGHT))
                 ? LINE_W'(rd_sum - (LINE_W+1)'(SCREEN_HEIGHT)) : LINE_W'(rd_sum);
        top_inc  = (top_reg == LINE_W'(SCREEN_HEIGHT - 1)) ? '0 : top_reg + 1'b1;
    end

    always_comb begin
        col_next    = col_reg;
        line_next   = line_reg;
        top_next    = top_reg;
        advance     = 1'b0;
        put_wr      = 1'b0;
        acc_flag    = 1'b1;
        scroll_flag = 1'b0;
        read_ok     = 1'b0;
        stop        = STOP_W'(col_reg) + 1'b1;
        stop_col    = stop;
        dl          = 2'd0;
        line_sum    = '0;
        unique case (s_kind)
            KIND_PUT: begin
                if (s_char_code == CODE_TAB) begin
                    stop    = tab_stop_tbl[col_reg];
                    advance = 1'b1;
                end else if (s_char_code == CODE_NEWLINE) begin
                    stop    = STOP_W'(col_reg) + STOP_W'(SCREEN_WIDTH);
                    advance = 1'b1;
                end else if (s_char_code == CODE_RETURN) begin
                    col_next = '0;
                end else if (s_char_code == CODE_BACKSPACE) begin
                    if (col_reg != '0) begin
                        col_next = col_reg - 1'b1;
                    end else if (line_reg != '0) begin
                        col_next  = COL_W'(SCREEN_WIDTH - 1);
                        line_next = line_reg - 1'b1;
                    end
                end else begin
                    put_wr  = 1'b1;
                    advance = 1'b1;
                end
            end
            KIND_SET_COL: begin
                if (s_target_index < 8'(SCREEN_WIDTH)) begin
                    col_next = s_target_index[COL_W-1:0];
                end else begin
                    acc_flag = 1'b0;
                end
            end
            KIND_SET_LINE: begin
                if (s_target_index < 8'(SCREEN_HEIGHT)) begin
                    line_next = s_target_index[LINE_W-1:0];
                end else begin
                    acc_flag = 1'b0;
                end
            end
            KIND_READ: begin
                if (({1'b0, s_read_column} < 8'(SCREEN_WIDTH))
                        && ({1'b0, s_read_line} < 6'(SCREEN_HEIGHT))) begin
                    read_ok = 1'b1;
                end else begin
                    acc_flag = 1'b0;
                end
            end
            default: begin
                acc_flag = 1'b0;
            end
        endcase

        // Fold the advanced column back into the screen width; a tab can
        // cross two lines on a screen narrower than the tab spacing.
        if (advance) begin
            if (stop >= STOP_W'(2 * SCREEN_WIDTH)) begin
                dl       = 2'd2;
                stop_col = stop - STOP_W'(2 * SCREEN_WIDTH);
            end else if (stop >= STOP_W'(SCREEN_WIDTH)) begin
                dl       = 2'd1;
                stop_col = stop - STOP_W'(SCREEN_WIDTH);
            end else begin
                dl       = 2'd0;
                stop_col = stop;
            end
            line_sum = (LINE_W+2)'(line_reg) + (LINE_W+2)'(dl);
            if (line_sum >= (LINE_W+2)'(SCREEN_HEIGHT)) begin
                scroll_flag = 1'b1;
                col_next    = '0;
                line_next   = LINE_W'(SCREEN_HEIGHT - 1);
                top_next    = top_inc;
            end else begin
                col_next  = stop_col[COL_W-1:0];
                line_next = line_sum[LINE_W-1:0];
            end
        end
    end

    always_comb begin
        mem_we  = cmd_i.clear || (cmd_i.exec && put_wr);
        wr_addr = cmd_i.clear ? {clr_row_reg, clr_col_reg} : {cur_phys, col_reg};
        wr_data = cmd_i.clear ? 16'd0 : {s_char_color, s_char_code};
        rd_addr = {rd_phys, s_read_column[COL_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd_i.exec && read_ok) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            line_reg    <= '0;
            top_reg     <= '0;
            clr_col_reg <= '0;
            clr_row_reg <= '0;
        end else if (cmd_i.exec) begin
            col_reg  <= col_next;
            line_reg <= line_next;
            top_reg  <= top_next;
            if (scroll_flag) begin
                // The old top row becomes the new bottom line.
                clr_row_reg <= top_reg;
                clr_col_reg <= '0;
            end
        end else if (cmd_i.clear) begin
            if (sts_o.clr_last_col) begin
                clr_col_reg <= '0;
                clr_row_reg <= sts_o.clr_last_row ? '0 : clr_row_reg + 1'b1;
            end else begin
                clr_col_reg <= clr_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.exec) begin
            res_acc_reg <= acc_flag;
            res_scr_reg <= scroll_flag;
            res_rd_reg  <= read_ok;
        end
        if (cmd_i.load_out) begin
            out_acc_reg  <= res_acc_reg;
            out_scr_reg  <= res_scr_reg;
            out_col_reg  <= col_reg;
            out_line_reg <= line_reg;
            out_cell_reg <= res_rd_reg ? rdata_reg : 16'd0;
        end
    end

    assign sts_o.scroll_req   = scroll_flag;
    assign sts_o.clr_last_col = (clr_col_reg == COL_W'(SCREEN_WIDTH - 1));
    assign sts_o.clr_last_row = (clr_row_reg == LINE_W'(SCREEN_HEIGHT - 1));

    assign m_accepted      = out_acc_reg;
    assign m_scrolled      = out_scr_reg;
    assign m_cursor_column = 7'(out_col_reg);
    assign m_cursor_line   = 5'(out_line_reg);
    assign m_cell_char     = out_cell_reg[7:0];
    assign m_cell_color    = out_cell_reg[15:8];

    // The cursor and the scroll offset stay on the screen.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, col_reg} < (COL_W+1)'(SCREEN_WIDTH))
            && ({1'b0, line_reg} < (LINE_W+1)'(SCREEN_HEIGHT))
            && ({1'b0, top_reg} < (LINE_W+1)'(SCREEN_HEIGHT)))
        else $error("cursor or scroll offset off screen");

    // A scroll always lands the cursor at the start of the bottom line.
    a_scroll_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.exec && scroll_flag) |=>
            (col_reg == '0) && (line_reg == LINE_W'(SCREEN_HEIGHT - 1)))
        else $error("scroll left cursor astray");

endmodule

// ===== sv/text_terminal_cursor_writer.sv =====
`timescale 1ns / 1ps

// Chan  Dir  Handshake        Payload
// s_    in   s_valid/s_ready  kind, char_code, char_color, target_index, read_column, read_line
// m_    out  m_valid/m_ready  accepted, cursor_column, cursor_line, scrolled, cell_char, cell_color
//
// A request passes through the accept cycle, which updates the cursor and writes or reads the
// cell, and the finish state, which loads the result register. A scrolling request adds a line
// clear state in which the single write port of the screen memory zeroes the new bottom line.
// After reset s_ready stays low while the screen memory is cleared.
// A result waiting on m_ready stalls the next request, once accepted, in its finish cycle.

module text_terminal_cursor_writer import ttcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int TAB_STOP      = TAB_STOP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_char_color,
    input  logic [7:0] s_target_index,
    input  logic [6:0] s_read_column,
    input  logic [4:0] s_read_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted,
    output logic [6:0] m_cursor_column,
    output logic [4:0] m_cursor_line,
    output logic       m_scrolled,
    output logic [7:0] m_cell_char,
    output logic [7:0] m_cell_color
);

    ttcw_cmd_t cmd;
    ttcw_sts_t sts;

    // The controller sequences the clear pass, request execution, line clears
    // on scroll and the hand-off into the result register.
    ttcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    // The datapath holds the cursor, the circular row offset that makes a
    // scroll cheap, the screen memory and the result register.
    ttcw_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TAB_STOP      (TAB_STOP)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_i           (cmd),
        .sts_o           (sts),
        .s_kind          (s_kind),
        .s_char_code     (s_char_code),
        .s_char_color    (s_char_color),
        .s_target_index  (s_target_index),
        .s_read_column   (s_read_column),
        .s_read_line     (s_read_line),
        .m_accepted      (m_accepted),
        .m_cursor_column (m_cursor_column),
        .m_cursor_line   (m_cursor_line),
        .m_scrolled      (m_scrolled),
        .m_cell_char     (m_cell_char),
        .m_cell_color    (m_cell_color)
    );

endmodule

// ===== bench/terminal_screen_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the terminal writer. It keeps its own copy of the
// screen and the cursor, predicts one result per accepted request, and compares
// each returned result with the oldest prediction.
module terminal_screen_checker import ttcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int TAB_STOP      = TAB_STOP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_char_color,
    input  logic [7:0] s_target_index,
    input  logic [6:0] s_read_column,
    input  logic [4:0] s_read_line,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_accepted,
    input  logic [6:0] m_cursor_column,
    input  logic [4:0] m_cursor_line,
    input  logic       m_scrolled,
    input  logic [7:0] m_cell_char,
    input  logic [7:0] m_cell_color,
    output int         error_count,
    output int         pending_count,
    output int         result_count,
    output int         scroll_count
);

    localparam int CELL_TOTAL = SCREEN_WIDTH * SCREEN_HEIGHT;

    typedef struct packed {
        logic       accepted;
        logic [6:0] cursor_column;
        logic [4:0] cursor_line;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } screen_reply_t;

    // Character in the low byte, color in the high byte.
    logic [15:0]   screen_copy [CELL_TOTAL];
    int unsigned   cursor_pos;
    screen_reply_t replies_due [$];
    int            errors;
    int            results;
    int            scrolls;

    function automatic screen_reply_t apply_request(
        input logic [1:0] kind,
        input logic [7:0] code,
        input logic [7:0] color,
        input logic [7:0] target,
        input logic [6:0] rcol,
        input logic [4:0] rrow
    );
        screen_reply_t reply;
        int unsigned   col;
        logic          past_end;
        reply          = '0;
        reply.accepted = 1'b1;
        col            = cursor_pos % SCREEN_WIDTH;
        past_end       = 1'b0;
        case (kind)
            KIND_PUT: begin
                if (code == CODE_TAB) begin
                    cursor_pos += TAB_STOP - (col % TAB_STOP);
                    past_end = (cursor_pos >= CELL_TOTAL);
                end else if (code == CODE_NEWLINE) begin
                    cursor_pos += SCREEN_WIDTH;
                    past_end = (cursor_pos >= CELL_TOTAL);
                end else if (code == CODE_RETURN) begin
                    cursor_pos -= col;
                end else if (code == CODE_BACKSPACE) begin
                    if (cursor_pos != 0) cursor_pos--;
                end else begin
                    screen_copy[cursor_pos] = {color, code};
                    cursor_pos++;
                    past_end = (cursor_pos >= CELL_TOTAL);
                end
                // Scroll: every line moves up one, the bottom line is blanked.
                if (past_end) begin
                    for (int i = 0; i < CELL_TOTAL - SCREEN_WIDTH; i++)
                        screen_copy[i] = screen_copy[i + SCREEN_WIDTH];
                    for (int i = CELL_TOTAL - SCREEN_WIDTH; i < CELL_TOTAL; i++)
                        screen_copy[i] = '0;
                    cursor_pos     = CELL_TOTAL - SCREEN_WIDTH;
                    reply.scrolled = 1'b1;
                end
            end
            KIND_SET_COL: begin
                if (target < SCREEN_WIDTH) cursor_pos = cursor_pos - col + target;
                else reply.accepted = 1'b0;
            end
            KIND_SET_LINE: begin
                if (target < SCREEN_HEIGHT) cursor_pos = col + target * SCREEN_WIDTH;
                else reply.accepted = 1'b0;
            end
            KIND_READ: begin
                if (rcol < SCREEN_WIDTH && rrow < SCREEN_HEIGHT) begin
                    {reply.cell_color, reply.cell_char} =
                        screen_copy[rrow * SCREEN_WIDTH + rcol];
                end else begin
                    reply.accepted = 1'b0;
                end
            end
        endcase
        reply.cursor_column = 7'(cursor_pos % SCREEN_WIDTH);
        reply.cursor_line   = 5'(cursor_pos / SCREEN_WIDTH);
        return reply;
    endfunction

    always @(posedge aclk) begin
        screen_reply_t got;
        screen_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELL_TOTAL; i++) screen_copy[i] = '0;
            cursor_pos = 0;
            replies_due.delete();
        end else begin
            // Results leave only from the result register, loaded after their request's accept cycle, so
            // the result side is handled before this cycle's request is queued.
            if (m_valid && m_ready) begin
                got = {m_accepted, m_cursor_column, m_cursor_line, m_scrolled,
                       m_cell_char, m_cell_color};
                if (replies_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request waiting: acc=%0b col=%0d row=%0d",
                                 $time, got.accepted, got.cursor_column, got.cursor_line);
                end else begin
                    want = replies_due.pop_front();
                    results++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: result %0d differs", $time, results);
                            $display("  expected acc=%0b col=%0d row=%0d scr=%0b chr=%02h clr=%02h",
                                     want.accepted, want.cursor_column, want.cursor_line,
                                     want.scrolled, want.cell_char, want.cell_color);
                            $display("  actual   acc=%0b col=%0d row=%0d scr=%0b chr=%02h clr=%02h",
                                     got.accepted, got.cursor_column, got.cursor_line,
                                     got.scrolled, got.cell_char, got.cell_color);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_request(s_kind, s_char_code, s_char_color, s_target_index,
                                     s_read_column, s_read_line);
                if (want.scrolled) scrolls++;
                replies_due.push_back(want);
            end
        end
        error_count   <= errors;
        pending_count <= replies_due.size();
        result_count  <= results;
        scroll_count  <= scrolls;
    end

endmodule

// ===== bench/text_terminal_cursor_writer_tb.sv =====
`timescale 1ns / 1ps

// Top of the terminal writer bench. This module only produces requests, paces
// both channels and gives the verdict; prediction and comparison live in the
// checker instantiated next to the block.
module text_terminal_cursor_writer_tb;
    import ttcw_pkg::*;

    // The block clears its whole screen after reset and a scroll clears a full
    // line, so the quiet-cycle limit is generous.
    localparam int IDLE_LIMIT     = 20000;
    localparam int TOTAL_REQUESTS = 500;
    localparam int DRAIN_CYCLES   = 2 * SCREEN_WIDTH_DEF + 16;
    localparam int DRAIN_EVERY    = 150;

    // Patterns that the result side cycles through when it stalls.
    typedef enum int {RX_ALWAYS, RX_HALF, RX_SLOW, RX_PERIODIC, RX_LONG_STALL} rx_mode_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic [1:0] s_kind         = KIND_PUT;
    logic [7:0] s_char_code    = '0;
    logic [7:0] s_char_color   = '0;
    logic [7:0] s_target_index = '0;
    logic [6:0] s_read_column  = '0;
    logic [4:0] s_read_line    = '0;
    logic       m_ready        = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic       m_accepted;
    logic [6:0] m_cursor_column;
    logic [4:0] m_cursor_line;
    logic       m_scrolled;
    logic [7:0] m_cell_char;
    logic [7:0] m_cell_color;

    int fails;
    int pending;
    int results;
    int scrolls;
    int requests_sent = 0;
    int burst_left    = 0;
    int next_drain    = DRAIN_EVERY;

    rx_mode_t ready_mode = RX_ALWAYS;
    int       mode_left  = 0;
    int       hold_left  = 0;

    always #5 aclk = ~aclk;

    text_terminal_cursor_writer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_char_code     (s_char_code),
        .s_char_color    (s_char_color),
        .s_target_index  (s_target_index),
        .s_read_column   (s_read_column),
        .s_read_line     (s_read_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_cursor_column (m_cursor_column),
        .m_cursor_line   (m_cursor_line),
        .m_scrolled      (m_scrolled),
        .m_cell_char     (m_cell_char),
        .m_cell_color    (m_cell_color)
    );

    terminal_screen_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_char_code     (s_char_code),
        .s_char_color    (s_char_color),
        .s_target_index  (s_target_index),
        .s_read_column   (s_read_column),
        .s_read_line     (s_read_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_cursor_column (m_cursor_column),
        .m_cursor_line   (m_cursor_line),
        .m_scrolled      (m_scrolled),
        .m_cell_char     (m_cell_char),
        .m_cell_color    (m_cell_color),
        .error_count     (fails),
        .pending_count   (pending),
        .result_count    (results),
        .scroll_count    (scrolls)
    );

    // Result-side back-pressure. Every so often a new pattern is chosen: fully
    // ready, coin-flip, mostly stalled, a fixed one-in-five stall, or long
    // stalls released for a single cycle. The changes are not tied to the
    // request flow, so stalls land on every phase of the block's work,
    // including the scroll walk and the cycle a result is loaded.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = rx_mode_t'($urandom_range(0, 4));
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (ready_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_HALF:     m_ready <= ($urandom_range(0, 1) == 1);
            RX_SLOW:     m_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_ready <= (mode_left % 5 != 0);
            default: begin
                if (hold_left == 0) hold_left = $urandom_range(5, 25);
                hold_left--;
                m_ready <= (hold_left == 0);
            end
        endcase
    end

    // Watchdog: the run is stuck if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no handshake for %0d cycles, %0d results still due.",
                 IDLE_LIMIT, pending);
        $display("[text_terminal_cursor_writer] ERROR");
        $finish;
    end

    // The sender works in bursts. When a burst runs out, valid may drop for a
    // random gap; about a third of the bursts follow on without any gap.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Presents one request and holds it, unchanged, until the block takes it.
    // The ready seen right after the edge is the value the edge sampled.
    task automatic send_request(
        input logic [1:0] kind,
        input logic [7:0] code,
        input logic [7:0] color,
        input logic [7:0] target,
        input logic [6:0] rcol,
        input logic [4:0] rrow
    );
        pace_sender();
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_char_code    <= code;
        s_char_color   <= color;
        s_target_index <= target;
        s_read_column  <= rcol;
        s_read_line    <= rrow;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // The wrappers below fill the fields that a kind ignores with random
    // values, so those bits toggle without changing the outcome.
    task automatic put_char(input logic [7:0] code, input logic [7:0] color);
        send_request(KIND_PUT, code, color, 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    task automatic set_column(input logic [7:0] target);
        send_request(KIND_SET_COL, 8'($urandom), 8'($urandom), target,
                     7'($urandom), 5'($urandom));
    endtask

    task automatic set_row(input logic [7:0] target);
        send_request(KIND_SET_LINE, 8'($urandom), 8'($urandom), target,
                     7'($urandom), 5'($urandom));
    endtask

    task automatic read_cell(input logic [6:0] rcol, input logic [4:0] rrow);
        send_request(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), rcol, rrow);
    endtask

    // Holds the sender off until every predicted result has come back. The checker
    // publishes its count through a register, so the task lets it update before it looks.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Any byte that is stored on the screen rather than moving the cursor.
    function automatic logic [7:0] pick_printable();
        logic [7:0] code;
        do code = 8'($urandom_range(0, 255));
        while (code == CODE_TAB || code == CODE_NEWLINE ||
               code == CODE_RETURN || code == CODE_BACKSPACE);
        return code;
    endfunction

    initial begin
        int pick;
        int run_len;
        int r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests. The screen must read back as zeros after reset,
        // and a backspace at the very first position must leave the cursor
        // where it is.
        read_cell(7'd0, 5'd0);
        put_char(CODE_BACKSPACE, 8'hFF);
        // Extremes of the character and color bytes, code zero included.
        put_char(8'h41, 8'hFF);
        put_char(8'hFF, 8'h00);
        put_char(8'h00, 8'h80);
        // Backspace moves back without erasing; the read shows the cell before the cursor.
        put_char(CODE_BACKSPACE, 8'h00);
        read_cell(7'd1, 5'd0);
        // Tab to the next stop, then return to the start of the line.
        put_char(CODE_TAB, 8'h00);
        put_char(CODE_RETURN, 8'h00);
        // A tab from the last column wraps onto the next line, and a
        // backspace from column zero steps back onto the line above.
        set_column(8'd79);
        put_char(CODE_TAB, 8'h00);
        put_char(CODE_BACKSPACE, 8'h00);
        // Out-of-range set requests are refused and change nothing.
        set_column(8'd80);
        set_column(8'd255);
        set_row(8'd25);
        set_row(8'd255);
        // A character in the very last position scrolls the screen; the
        // character then sits on the line above the blank bottom line.
        set_row(8'd24);
        set_column(8'd79);
        put_char(8'h5A, 8'h5A);
        read_cell(7'd79, 5'd23);
        // A newline on the bottom line scrolls as well.
        put_char(CODE_NEWLINE, 8'h00);
        // So does a tab that runs past the end of the bottom line.
        set_column(8'd76);
        put_char(CODE_TAB, 8'h00);
        // Reads outside the screen are refused, up to the all-ones corner.
        read_cell(7'd127, 5'd31);
        read_cell(7'd80, 5'd0);
        read_cell(7'd0, 5'd25);

        // First hold-off: the block drains completely before random traffic.
        wait_for_results();

        // Random traffic built from short scenarios. The cursor is often sent
        // to the bottom lines so that text, tabs and newlines there scroll
        // the screen, and reads favor the lines that see the writes.
        while (requests_sent < TOTAL_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                run_len = $urandom_range(1, 8);
                repeat (run_len) put_char(pick_printable(), 8'($urandom));
            end else if (pick < 50) begin
                r = $urandom_range(0, 5);
                if (r < 2) put_char(CODE_NEWLINE, 8'($urandom));
                else if (r < 3) put_char(CODE_TAB, 8'($urandom));
                else if (r < 4) put_char(CODE_RETURN, 8'($urandom));
                else put_char(CODE_BACKSPACE, 8'($urandom));
            end else if (pick < 58) begin
                if ($urandom_range(0, 4) == 0) set_column(8'($urandom_range(0, 255)));
                else set_column(8'($urandom_range(0, 79)));
            end else if (pick < 68) begin
                r = $urandom_range(0, 9);
                if (r < 6) set_row(8'($urandom_range(22, 24)));
                else if (r < 8) set_row(8'($urandom_range(0, 24)));
                else set_row(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                if ($urandom_range(0, 9) < 7)
                    read_cell(7'($urandom_range(0, 79)), 5'($urandom_range(18, 24)));
                else
                    read_cell(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
            end else begin
                // Noise: any kind with every field random.
                send_request(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             7'($urandom), 5'($urandom));
            end

            if (requests_sent >= next_drain) begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
        end

        // All requests are in: collect the remaining results, then give the
        // block time to show any result that nothing asked for.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results against the prediction.",
                 requests_sent, results);
        $display("The screen scrolled %0d times; %0d results differed or were unexpected.",
                 scrolls, fails);
        if (fails == 0 && pending == 0) begin
            $display("[text_terminal_cursor_writer] OK");
        end else begin
            $display("[text_terminal_cursor_writer] ERROR");
        end
        $finish;
    end

endmodule
